// ===== design/pwo_pkg.sv =====
// Shared types, constants and the exp2 factor table of the orbit integrator.
`timescale 1ns / 1ps
package pwo_pkg;

  // Fixed-point fraction bits of positions, velocities and forces
  localparam int FRAC_BITS = 16;

  // Micro-program operations
  typedef enum logic [2:0] {
    OP_FORCE  = 3'd0,
    OP_KICK16 = 3'd1,
    OP_KICK17 = 3'd2,
    OP_DRIFT  = 3'd3,
    OP_HCALC  = 3'd4,
    OP_DONE   = 3'd5
  } op_t;

  // Step size selection
  typedef enum logic [1:0] {
    HS_FULL = 2'd0,
    HS_H1   = 2'd1,
    HS_H0   = 2'd2
  } hsel_t;

  typedef struct packed {
    op_t   op;
    hsel_t hsel;
  } prog_t;

  typedef enum logic [1:0] {
    MODE_EULER   = 2'd0,
    MODE_SYMPL   = 2'd1,
    MODE_VERLET  = 2'd2,
    MODE_YOSHIDA = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_EXPONENT = 2'd0,
    REG_TIMESTEP = 2'd1,
    REG_MODE     = 2'd2,
    REG_TOTAL    = 2'd3
  } reg_t;

  // Yoshida weights in Q.30
  localparam logic signed [32:0] W1_Q30 = 33'sd1450847675;
  localparam logic signed [32:0] W0_Q30 = -33'sd1827953526;
  localparam logic [31:0]        ONE_Q30 = 32'h4000_0000;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != '0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // Factors 2^(2^-k) in Q.30, k = 1..16, by repeated integer square roots
  function automatic logic [15:0][31:0] exp_tab();
    logic [15:0][31:0] tab;
    logic [63:0]       c;
    c = 64'd1 << 31;
    for (int k = 0; k < 16; k++) begin
      c           = isqrt64(c << 30);
      tab[4'(k)]  = c[31:0];
    end
    return tab;
  endfunction

  localparam logic [15:0][31:0] EXP_TAB = exp_tab();

  // Solver programs
  function automatic prog_t prog(input mode_t mode, input logic [4:0] pc);
    prog_t p;
    p.op   = OP_DONE;
    p.hsel = HS_FULL;
    case (mode)
      MODE_EULER: begin
        case (pc)
          5'd0:    p.op = OP_FORCE;
          5'd1:    p.op = OP_DRIFT;
          5'd2:    p.op = OP_KICK16;
          default: p.op = OP_DONE;
        endcase
      end
      MODE_SYMPL: begin
        case (pc)
          5'd0:    p.op = OP_FORCE;
          5'd1:    p.op = OP_KICK16;
          5'd2:    p.op = OP_DRIFT;
          default: p.op = OP_DONE;
        endcase
      end
      MODE_VERLET: begin
        case (pc)
          5'd0, 5'd3: p.op = OP_FORCE;
          5'd1, 5'd4: p.op = OP_KICK17;
          5'd2:       p.op = OP_DRIFT;
          default:    p.op = OP_DONE;
        endcase
      end
      default: begin
        case (pc)
          5'd0:                                  p.op = OP_HCALC;
          5'd1, 5'd4, 5'd6, 5'd9, 5'd11, 5'd14:  p.op = OP_FORCE;
          5'd2, 5'd5, 5'd7, 5'd10, 5'd12, 5'd15: p.op = OP_KICK17;
          5'd3, 5'd8, 5'd13:                     p.op = OP_DRIFT;
          default:                               p.op = OP_DONE;
        endcase
        if (pc <= 5'd5) p.hsel = HS_H1;
        else if (pc <= 5'd10) p.hsel = HS_H0;
        else p.hsel = HS_H1;
      end
    endcase
    return p;
  endfunction

endpackage

// ===== design/pwo_if.sv =====
// Word channels of the orbit integrator: start state in, position out.
`timescale 1ns / 1ps
interface pwo_in_if;
  logic               valid;
  logic               ready;
  logic               restart;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_vx;
  logic signed [31:0] start_vy;
  modport source(output valid, restart, start_x, start_y, start_vx, start_vy, input ready);
  modport sink(input valid, restart, start_x, start_y, start_vx, start_vy, output ready);
endinterface

interface pwo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  logic               last_step;
  logic               saturated;
  modport source(output valid, pos_x_out, pos_y_out, last_step, saturated, input ready);
  modport sink(input valid, pos_x_out, pos_y_out, last_step, saturated, output ready);
endinterface

// ===== design/powerlaw_orbit_integrator.sv =====
// Top level of the planar power-law orbit integrator.
//
//  channel  dir  handshake      word
//  in_ch    in   valid/ready    restart, start_x, start_y, start_vx, start_vy
//  out_ch   out  valid/ready    pos_x_out, pos_y_out, last_step, saturated
//  apb      in   psel/penable   exponent, time step, solver mode, step total
//
// One word is worked at a time; in_ch.ready is high only while idle.
// Each force evaluation runs on the single shared multiplier (two squares,
// 6 normalise steps, 16 log2 squarings, 16 exp2 products, two scalings).
// A finished word waits in the output register while the next word is taken.
// rst_n clears control and state.
`timescale 1ns / 1ps
module powerlaw_orbit_integrator (
  input  logic         clk,
  input  logic         rst_n,
  pwo_in_if.sink       in_ch,
  pwo_out_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_FETCH = 22'h000002,
    S_H1    = 22'h000004,
    S_H0    = 22'h000008,
    S_HE    = 22'h000010,
    S_SQX   = 22'h000020,
    S_SQY   = 22'h000040,
    S_SQS   = 22'h000080,
    S_NORM  = 22'h000100,
    S_LOGM  = 22'h000200,
    S_LOGU  = 22'h000400,
    S_TM    = 22'h000800,
    S_TU    = 22'h001000,
    S_EXPM  = 22'h002000,
    S_EXPU  = 22'h004000,
    S_SCX   = 22'h008000,
    S_SCY   = 22'h010000,
    S_SCE   = 22'h020000,
    S_AX    = 22'h040000,
    S_AY    = 22'h080000,
    S_AE    = 22'h100000,
    S_FIN   = 22'h200000
  } state_t;

  localparam logic signed [7:0] TWO_F = 8'(2 * pwo_pkg::FRAC_BITS);

  // configuration registers
  logic signed [7:0]  exponent_r;
  logic [16:0]        time_step_r;
  logic [1:0]         solver_mode_r;
  logic [15:0]        step_total_r;

  // sequencer and datapath registers
  state_t             state_r, state_nxt;
  logic [4:0]         pc_r, pc_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [63:0]        s_r, s_nxt;
  logic [5:0]         n_r, n_nxt;
  logic [30:0]        m_r, m_nxt;
  logic [15:0]        frac_r, frac_nxt;
  logic signed [12:0] ti_r, ti_nxt;
  logic [15:0]        tf_r, tf_nxt;
  logic [31:0]        p_r, p_nxt;
  logic signed [31:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [18:0] h1_r, h1_nxt, h0_r, h0_nxt;
  logic               sat_r, sat_nxt;
  logic [15:0]        sidx_r, sidx_nxt;
  logic               ov_r, ov_nxt;
  logic signed [31:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic               olast_r, olast_nxt, osat_r, osat_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;

  pwo_pkg::prog_t     cur;
  logic signed [32:0] hs;
  logic signed [32:0] ax_mag, ay_mag;
  logic signed [13:0] sh;
  logic signed [23:0] lg;
  logic signed [8:0]  e_m16;
  logic               kick;
  logic [4:0]         post_sh;
  logic signed [52:0] prod_sh;
  logic               cfg_wr;
  logic               in_acc;
  logic [32:0]        r_fx, r_fy, r_ax, r_ay;

  pwo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));

  // -sign(q) * m * 2^s, clamped; {saturated, value}
  function automatic logic [32:0] scale_force(input logic signed [31:0] q,
                                              input logic [63:0] m,
                                              input logic signed [13:0] s);
    logic        neg;
    logic [95:0] sv;
    logic [95:0] lim;
    logic [13:0] rs;
    logic [31:0] r;
    logic        st;
    neg = (q > 0);
    lim = neg ? 96'h8000_0000 : 96'h7FFF_FFFF;
    rs  = 14'(-s);
    st  = 1'b0;
    if (s < 0) begin
      if (rs >= 14'd64) sv = '0;
      else sv = {32'd0, m >> rs[5:0]};
    end else if (m == '0) begin
      sv = '0;
    end else if (s >= 14'sd32) begin
      sv = '1;
    end else begin
      sv = {32'd0, m} << s[4:0];
    end
    if (sv > lim) begin
      r  = lim[31:0];
      st = 1'b1;
    end else begin
      r = sv[31:0];
    end
    return {st, neg ? (32'd0 - r) : r};
  endfunction

  // Clamp to the signed 32-bit range; {saturated, value}
  function automatic logic [32:0] sat32(input logic signed [52:0] v);
    if (v > 53'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (v < -53'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // configuration port: writes land on the access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (pwo_pkg::reg_t'(paddr[3:2]))
      pwo_pkg::REG_EXPONENT: prdata = {24'd0, exponent_r};
      pwo_pkg::REG_TIMESTEP: prdata = {15'd0, time_step_r};
      pwo_pkg::REG_MODE:     prdata = {30'd0, solver_mode_r};
      pwo_pkg::REG_TOTAL:    prdata = {16'd0, step_total_r};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r    <= -8'sd8;
      time_step_r   <= 17'd1024;
      solver_mode_r <= pwo_pkg::MODE_EULER;
      step_total_r  <= 16'd100;
    end else if (cfg_wr) begin
      case (pwo_pkg::reg_t'(paddr[3:2]))
        pwo_pkg::REG_EXPONENT: exponent_r    <= pwdata[7:0];
        pwo_pkg::REG_TIMESTEP: time_step_r   <= pwdata[16:0];
        pwo_pkg::REG_MODE:     solver_mode_r <= pwdata[1:0];
        pwo_pkg::REG_TOTAL:    step_total_r  <= pwdata[15:0];
        default:               exponent_r    <= exponent_r;
      endcase
    end
  end

  // handshakes
  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = ov_r;
  assign out_ch.pos_x_out = ox_r;
  assign out_ch.pos_y_out = oy_r;
  assign out_ch.last_step = olast_r;
  assign out_ch.saturated = osat_r;

  // decode helpers
  assign cur     = pwo_pkg::prog(pwo_pkg::mode_t'(solver_mode_r), pc_r);
  assign ax_mag  = px_r[31] ? (33'sd0 - 33'(px_r)) : 33'(px_r);
  assign ay_mag  = py_r[31] ? (33'sd0 - 33'(py_r)) : 33'(py_r);
  assign sh      = 14'(ti_r) - 14'sd30;
  assign lg      = $signed({$signed({2'b00, n_r}) - TWO_F, frac_r});
  assign e_m16   = 9'(exponent_r) - 9'sd16;
  assign kick    = (cur.op == pwo_pkg::OP_KICK16) || (cur.op == pwo_pkg::OP_KICK17);
  assign post_sh = (cur.op == pwo_pkg::OP_KICK17) ? 5'd17 : 5'd16;
  assign prod_sh = 53'(prod_r >>> post_sh);
  assign r_fx    = scale_force(px_r, prod_r[63:0], sh);
  assign r_fy    = scale_force(py_r, prod_r[63:0], sh);
  assign r_ax    = sat32(53'(kick ? vx_r : px_r) + prod_sh);
  assign r_ay    = sat32(53'(kick ? vy_r : py_r) + prod_sh);

  always_comb begin
    case (cur.hsel)
      pwo_pkg::HS_H1: hs = 33'(h1_r);
      pwo_pkg::HS_H0: hs = 33'(h0_r);
      default:        hs = $signed({16'd0, time_step_r});
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    s_nxt     = s_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    frac_nxt  = frac_r;
    ti_nxt    = ti_r;
    tf_nxt    = tf_r;
    p_nxt     = p_r;
    fx_nxt    = fx_r;
    fy_nxt    = fy_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    h1_nxt    = h1_r;
    h0_nxt    = h0_r;
    sat_nxt   = sat_r;
    sidx_nxt  = sidx_r;
    ov_nxt    = ov_r && !out_ch.ready;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    olast_nxt = olast_r;
    osat_nxt  = osat_r;
    mul_a     = '0;
    mul_b     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sat_nxt   = 1'b0;
          pc_nxt    = '0;
          state_nxt = S_FETCH;
          if (in_ch.restart) begin
            px_nxt   = in_ch.start_x;
            py_nxt   = in_ch.start_y;
            vx_nxt   = in_ch.start_vx;
            vy_nxt   = in_ch.start_vy;
            sidx_nxt = '0;
          end
        end
      end
      S_FETCH: begin
        case (cur.op)
          pwo_pkg::OP_HCALC: state_nxt = S_H1;
          pwo_pkg::OP_FORCE: state_nxt = S_SQX;
          pwo_pkg::OP_DONE:  state_nxt = S_FIN;
          default:           state_nxt = S_AX;
        endcase
      end
      // Yoshida sub-step sizes
      S_H1: begin
        mul_a     = pwo_pkg::W1_Q30;
        mul_b     = $signed({16'd0, time_step_r});
        state_nxt = S_H0;
      end
      S_H0: begin
        mul_a     = pwo_pkg::W0_Q30;
        mul_b     = $signed({16'd0, time_step_r});
        h1_nxt    = prod_r[48:30];
        state_nxt = S_HE;
      end
      S_HE: begin
        h0_nxt    = prod_r[48:30];
        pc_nxt    = pc_r + 5'd1;
        state_nxt = S_FETCH;
      end
      // radius squared
      S_SQX: begin
        mul_a     = ax_mag;
        mul_b     = ax_mag;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        mul_a     = ay_mag;
        mul_b     = ay_mag;
        s_nxt     = prod_r[63:0];
        state_nxt = S_SQS;
      end
      S_SQS: begin
        s_nxt     = s_r + prod_r[63:0];
        n_nxt     = 6'd63;
        cnt_nxt   = '0;
        frac_nxt  = '0;
        state_nxt = S_NORM;
      end
      // binary-search normalise: bring the leading one to bit 63
      S_NORM: begin
        if (s_r == '0) begin
          fx_nxt    = '0;
          fy_nxt    = '0;
          sat_nxt   = 1'b1;
          pc_nxt    = pc_r + 5'd1;
          state_nxt = S_FETCH;
        end else begin
          case (cnt_r)
            4'd0:    if (s_r[63:32] == '0) begin s_nxt = s_r << 32; n_nxt = n_r - 6'd32; end
            4'd1:    if (s_r[63:48] == '0) begin s_nxt = s_r << 16; n_nxt = n_r - 6'd16; end
            4'd2:    if (s_r[63:56] == '0) begin s_nxt = s_r << 8;  n_nxt = n_r - 6'd8;  end
            4'd3:    if (s_r[63:60] == '0) begin s_nxt = s_r << 4;  n_nxt = n_r - 6'd4;  end
            4'd4:    if (s_r[63:62] == '0) begin s_nxt = s_r << 2;  n_nxt = n_r - 6'd2;  end
            default: if (!s_r[63])         begin s_nxt = s_r << 1;  n_nxt = n_r - 6'd1;  end
          endcase
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd5) begin
            m_nxt     = s_nxt[63:33];
            cnt_nxt   = '0;
            state_nxt = S_LOGM;
          end
        end
      end
      // log2 by repeated squaring, one fraction bit per pass
      S_LOGM: begin
        mul_a     = {2'b00, m_r};
        mul_b     = {2'b00, m_r};
        state_nxt = S_LOGU;
      end
      S_LOGU: begin
        if (prod_r[61]) begin
          m_nxt    = prod_r[61:31];
          frac_nxt = {frac_r[14:0], 1'b1};
        end else begin
          m_nxt    = prod_r[60:30];
          frac_nxt = {frac_r[14:0], 1'b0};
        end
        cnt_nxt   = cnt_r + 4'd1;
        state_nxt = (cnt_r == 4'd15) ? S_TM : S_LOGM;
      end
      // exponent of two: t = log2(r^2) * (a-2)/2 in Q.20
      S_TM: begin
        mul_a     = 33'(lg);
        mul_b     = 33'(e_m16);
        state_nxt = S_TU;
      end
      S_TU: begin
        ti_nxt    = prod_r[32:20];
        tf_nxt    = prod_r[19:4];
        p_nxt     = pwo_pkg::ONE_Q30;
        cnt_nxt   = '0;
        state_nxt = S_EXPM;
      end
      // exp2 of the fraction, one factor per bit
      S_EXPM: begin
        mul_a     = {1'b0, p_r};
        mul_b     = {1'b0, pwo_pkg::EXP_TAB[cnt_r]};
        state_nxt = S_EXPU;
      end
      S_EXPU: begin
        if (tf_r[4'd15 - cnt_r]) p_nxt = prod_r[61:30];
        cnt_nxt   = cnt_r + 4'd1;
        state_nxt = (cnt_r == 4'd15) ? S_SCX : S_EXPM;
      end
      // scale the components by the power
      S_SCX: begin
        mul_a     = ax_mag;
        mul_b     = {1'b0, p_r};
        state_nxt = S_SCY;
      end
      S_SCY: begin
        mul_a     = ay_mag;
        mul_b     = {1'b0, p_r};
        fx_nxt    = r_fx[31:0];
        sat_nxt   = sat_r | r_fx[32];
        state_nxt = S_SCE;
      end
      S_SCE: begin
        fy_nxt    = r_fy[31:0];
        sat_nxt   = sat_r | r_fy[32];
        pc_nxt    = pc_r + 5'd1;
        state_nxt = S_FETCH;
      end
      // kick (velocity += force * h) or drift (position += velocity * h)
      S_AX: begin
        mul_a     = 33'(kick ? fx_r : vx_r);
        mul_b     = hs;
        state_nxt = S_AY;
      end
      S_AY: begin
        mul_a = 33'(kick ? fy_r : vy_r);
        mul_b = hs;
        if (kick) vx_nxt = r_ax[31:0];
        else px_nxt = r_ax[31:0];
        sat_nxt   = sat_r | r_ax[32];
        state_nxt = S_AE;
      end
      S_AE: begin
        if (kick) vy_nxt = r_ay[31:0];
        else py_nxt = r_ay[31:0];
        sat_nxt   = sat_r | r_ay[32];
        pc_nxt    = pc_r + 5'd1;
        state_nxt = S_FETCH;
      end
      // hold until the output register is free
      S_FIN: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          ox_nxt    = px_r;
          oy_nxt    = py_r;
          osat_nxt  = sat_r;
          olast_nxt = ((sidx_r + 16'd1) == step_total_r);
          sidx_nxt  = olast_nxt ? 16'd0 : sidx_r + 16'd1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      cnt_r   <= '0;
      px_r    <= '0;
      py_r    <= '0;
      vx_r    <= '0;
      vy_r    <= '0;
      sidx_r  <= '0;
      sat_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      cnt_r   <= cnt_nxt;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      vx_r    <= vx_nxt;
      vy_r    <= vy_nxt;
      sidx_r  <= sidx_nxt;
      sat_r   <= sat_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    n_r     <= n_nxt;
    m_r     <= m_nxt;
    frac_r  <= frac_nxt;
    ti_r    <= ti_nxt;
    tf_r    <= tf_nxt;
    p_r     <= p_nxt;
    fx_r    <= fx_nxt;
    fy_r    <= fy_nxt;
    h1_r    <= h1_nxt;
    h0_r    <= h0_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    olast_r <= olast_nxt;
    osat_r  <= osat_nxt;
  end

  // a result word only appears from the finishing state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == S_FIN))
    else $error("result word raised outside finish");

  // normalisation leaves the leading one at the top
  a_norm_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOGM && $past(state_r == S_NORM)) |-> s_r[63])
    else $error("radius squared not normalised");

  // log2 mantissa stays within [1,2)
  a_log_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOGM) |-> m_r[30])
    else $error("log2 mantissa out of range");

endmodule

// ===== design/pwo_mul.sv =====
// Shared signed 33x33 multiplier with registered product.
`timescale 1ns / 1ps
module pwo_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod_r
);
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end
endmodule
